// ===== design/spectrum_bar_falloff_peak_hold_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum bar falloff and peak hold core
// Immediate-consequence and next-cycle checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAR_FALLOFF_PEAK_HOLD_CORE_ASSERT_SVH
`define SPECTRUM_BAR_FALLOFF_PEAK_HOLD_CORE_ASSERT_SVH

// consequence holds in the same cycle as the antecedent
`define SBFPH_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the cycle after the antecedent
`define SBFPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sbfph_pkg.sv =====
// ----------------------------------------------------------------------------
// sbfph_pkg
// Shared types and constants of the spectrum bar falloff and peak hold core.
// ----------------------------------------------------------------------------
`default_nettype none

package sbfph_pkg;

   localparam int COL_W  = 6;
   localparam int LVL_W  = 5;
   localparam int HGT_W  = 8;
   localparam int BAR_W  = 8;
   localparam int PROD_W = LVL_W + HGT_W;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;
   localparam int MODE_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAR_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAKS_ENABLED = 2'd2;

   // channel modes; any other code selects the larger of both
   localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd1;

   // command codes
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // state kept per column and channel set
   typedef struct packed {
      logic [BAR_W-1:0] show;
      logic [BAR_W-1:0] peak;
      logic [BAR_W-1:0] fall;
   } entry_type;

endpackage

`default_nettype wire

// ===== design/sbfph_ram.sv =====
// ----------------------------------------------------------------------------
// sbfph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfph_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 192,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sbfph_scale.sv =====
// ----------------------------------------------------------------------------
// sbfph_scale
// Divides level times bar height by the dB step count via a reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfph_scale
   import sbfph_pkg::*;
#(
   parameter int DB_STEPS = 32
) (
   input  wire logic [PROD_W-1:0] prod,
   output logic      [BAR_W-1:0]  scaled
);

   // exact for every product below 2**PROD_W with this shift and rounding
   localparam int SHIFT = PROD_W + $clog2(DB_STEPS);
   localparam int REC_W = PROD_W + 1;
   localparam int MUL_W = PROD_W + REC_W;
   localparam longint unsigned RECIP =
      ((64'd1 << SHIFT) + longint'(DB_STEPS) - 64'd1) / longint'(DB_STEPS);
   localparam logic [REC_W-1:0] RECIP_V = REC_W'(RECIP);

   logic [MUL_W-1:0] mul;
   logic [15:0]      quot;

   assign mul  = MUL_W'(prod) * MUL_W'(RECIP_V);
   assign quot = 16'(mul >> SHIFT);

   // saturate at full byte scale
   assign scaled = (quot > 16'd255) ? 8'hFF : quot[BAR_W-1:0];

endmodule

`default_nettype wire

// ===== design/sbfph_update.sv =====
// ----------------------------------------------------------------------------
// sbfph_update
// Next bar, peak and fall speed of one column from its stored state.
// ----------------------------------------------------------------------------
`default_nettype none

module sbfph_update
   import sbfph_pkg::*;
(
   input  wire entry_type        cur,
   input  wire logic [BAR_W-1:0] scaled,
   output entry_type             nxt
);

   logic [BAR_W-1:0] show;
   logic [BAR_W-1:0] peak;
   logic [BAR_W-1:0] fall;

   always_comb begin
      show = cur.show;
      peak = cur.peak;
      fall = cur.fall;

      // drop by the fall speed and accelerate, or floor at zero
      if (scaled < show) begin
         if (show >= fall) begin
            show = show - fall;
            if (fall != 8'hFF) begin
               fall = fall + 8'd1;
            end
         end else begin
            show = '0;
         end
      end

      // jump up and restart the fall
      if (scaled > show) begin
         show = scaled;
         fall = 8'd1;
      end

      if (peak <= scaled) begin
         peak = (scaled == 8'hFF) ? 8'hFF : scaled + 8'd1;
      end else if ((peak != '0) && ({1'b0, peak} > ({1'b0, show} + 9'd1))) begin
         peak = peak - 8'd1;
      end

      nxt.show = show;
      nxt.peak = peak;
      nxt.fall = fall;
   end

endmodule

`default_nettype wire

// ===== design/spectrum_bar_falloff_peak_hold_core.sv =====
// A beat is registered in stage one and then in the result register.
// Throughput: one beat per cycle unless responses stall; the store is read
// at accept, written as stage one fires, with a bypass on back-to-back hits.
// Reset: channel_mode 1, bar_height 64, peaks_enabled 1; all column state
// reads as zero through per-entry valid bits, so no clearing pass is needed.
// A clear beat drops every valid bit in the cycle it completes.
`default_nettype none

`include "spectrum_bar_falloff_peak_hold_core_assert.svh"

// ----------------------------------------------------------------------------
// spectrum_bar_falloff_peak_hold_core
// Per-column spectrum bar animator with peak hold and accelerating falloff.
// ----------------------------------------------------------------------------
module spectrum_bar_falloff_peak_hold_core
   import sbfph_pkg::*;
#(
   parameter int COLUMNS  = 64,
   parameter int DB_STEPS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata,

   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [COL_W-1:0]     req_column,
   input  wire logic [LVL_W-1:0]     req_level_left,
   input  wire logic [LVL_W-1:0]     req_level_right,

   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [COL_W-1:0]     rsp_out_column,
   output logic      [BAR_W-1:0]     rsp_scaled_level,
   output logic      [BAR_W-1:0]     rsp_bar_shown,
   output logic      [BAR_W-1:0]     rsp_bar_previous,
   output logic      [BAR_W-1:0]     rsp_peak_marker,
   output logic      [BAR_W-1:0]     rsp_fall_speed
);

   // the column field cannot address more than 2**COL_W columns
   localparam int COLS_USED = (COLUMNS < (1 << COL_W)) ? COLUMNS : (1 << COL_W);
   localparam int DEPTH     = 3 * COLS_USED;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int ENTRY_W   = $bits(entry_type);
   localparam logic [LVL_W-1:0] LVL_MAX =
      LVL_W'((DB_STEPS > (1 << LVL_W)) ? ((1 << LVL_W) - 1) : (DB_STEPS - 1));

   // configuration
   logic [MODE_W-1:0] mode_ff;
   logic [HGT_W-1:0]  height_ff;
   logic              peaks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RIGHT;
         height_ff <= 8'd64;
         peaks_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_MODE:  mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_BAR_HEIGHT:    height_ff <= csr_wdata[HGT_W-1:0];
            CSR_PEAKS_ENABLED: peaks_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // request side: pick channel, clamp, multiply, address the store
   logic [LVL_W-1:0]  lvl_l;
   logic [LVL_W-1:0]  lvl_r;
   logic [LVL_W-1:0]  lvl_sel;
   logic [1:0]        set_sel;
   logic              req_fire;
   logic              col_ok_in;
   logic [ADDR_W-1:0] addr_in;
   logic [PROD_W-1:0] prod_in;

   assign lvl_l = (req_level_left  > LVL_MAX) ? LVL_MAX : req_level_left;
   assign lvl_r = (req_level_right > LVL_MAX) ? LVL_MAX : req_level_right;

   always_comb begin
      case (mode_ff)
         MODE_LEFT: begin
            set_sel = 2'd0;
            lvl_sel = lvl_l;
         end
         MODE_RIGHT: begin
            set_sel = 2'd1;
            lvl_sel = lvl_r;
         end
         default: begin
            set_sel = 2'd2;
            lvl_sel = (lvl_l > lvl_r) ? lvl_l : lvl_r;
         end
      endcase
   end

   assign col_ok_in = int'(req_column) < COLS_USED;
   assign addr_in   = ADDR_W'(int'(set_sel) * COLS_USED + int'(req_column));
   assign prod_in   = PROD_W'(lvl_sel) * PROD_W'(height_ff);
   assign req_fire  = req_valid && req_ready;

   // stage one
   logic              s1_vld_ff;
   logic              s1_cmd_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic              s1_ok_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic              s1_fire;
   logic              rsp_vld_ff;

   assign s1_fire   = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff  <= req_cmd;
         s1_col_ff  <= req_column;
         s1_ok_ff   <= col_ok_in;
         s1_addr_ff <= addr_in;
         s1_prod_ff <= prod_in;
      end
   end

   // column store, valid bits and write bypass
   logic              ram_we;
   logic              clear_go;
   entry_type         ram_rd;
   entry_type         cur;
   entry_type         nxt;
   logic [ENTRY_W-1:0] ram_rd_bits;
   logic [DEPTH-1:0]  vld_ff;
   logic              fwd_vld_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   entry_type         fwd_data_ff;

   assign ram_we   = s1_fire && (s1_cmd_ff == CMD_UPDATE) && s1_ok_ff;
   assign clear_go = s1_fire && (s1_cmd_ff == CMD_CLEAR);

   sbfph_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt),
      .rd_en   (req_fire),
      .rd_addr (addr_in),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd = ram_rd_bits;

   always_ff @(posedge clock) begin
      if (reset || clear_go) begin
         vld_ff     <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (ram_we) begin
         vld_ff[s1_addr_ff] <= 1'b1;
         fwd_vld_ff         <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         fwd_addr_ff <= s1_addr_ff;
         fwd_data_ff <= nxt;
      end
   end

   // the newest write wins over a read that raced it
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur = fwd_data_ff;
      end else if (vld_ff[s1_addr_ff]) begin
         cur = ram_rd;
      end else begin
         cur = '0;
      end
   end

   logic [BAR_W-1:0] scaled;

   sbfph_scale #(
      .DB_STEPS (DB_STEPS)
   ) u_scale (
      .prod   (s1_prod_ff),
      .scaled (scaled)
   );

   sbfph_update u_update (
      .cur    (cur),
      .scaled (scaled),
      .nxt    (nxt)
   );

   // result register
   logic [COL_W-1:0] col_ff;
   logic [BAR_W-1:0] lvl_ff;
   logic [BAR_W-1:0] show_ff;
   logic [BAR_W-1:0] prev_ff;
   logic [BAR_W-1:0] peak_ff;
   logic [BAR_W-1:0] fall_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         col_ff  <= s1_col_ff;
         lvl_ff  <= '0;
         show_ff <= '0;
         prev_ff <= '0;
         peak_ff <= '0;
         fall_ff <= '0;
         if (s1_cmd_ff == CMD_UPDATE) begin
            lvl_ff <= scaled;
            if (s1_ok_ff) begin
               show_ff <= nxt.show;
               prev_ff <= cur.show;
               peak_ff <= peaks_ff ? nxt.peak : '0;
               fall_ff <= nxt.fall;
            end
         end
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_out_column   = col_ff;
   assign rsp_scaled_level = lvl_ff;
   assign rsp_bar_shown    = show_ff;
   assign rsp_bar_previous = prev_ff;
   assign rsp_peak_marker  = peak_ff;
   assign rsp_fall_speed   = fall_ff;

   `SBFPH_ASSERT_SAME(a_write_only_update, clock, reset, ram_we,
      s1_vld_ff && (s1_cmd_ff == CMD_UPDATE) && s1_ok_ff,
      "store written by a beat that is not an in-range update")
   `SBFPH_ASSERT_NEXT(a_clear_kills_bypass, clock, reset, clear_go,
      !fwd_vld_ff && (vld_ff == '0),
      "column state survived a clear")
   `SBFPH_ASSERT_SAME(a_stall_blocks_req, clock, reset,
      s1_vld_ff && rsp_vld_ff && !rsp_ready, !req_ready,
      "request taken while stage one is held")
   `SBFPH_ASSERT_SAME(a_rise_to_level, clock, reset,
      rsp_vld_ff && (show_ff > prev_ff), show_ff == lvl_ff,
      "bar rose to a height other than the scaled level")

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spectrum bar falloff and peak hold core. It
// sends column updates and clears over the request channel, predicts every
// result from its own copy of the per-column bar state, and compares each
// response beat field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
   import sbfph_pkg::*;

   localparam int COLUMNS  = 64;
   localparam int DB_STEPS = 32;
   localparam int SETS     = 3;

   // modes that take the larger of both channels
   localparam logic [MODE_W-1:0] MODE_BOTH     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_BOTH_ALT = 2'd3;

   typedef struct packed {
      logic [COL_W-1:0] column;
      logic [BAR_W-1:0] scaled;
      logic [BAR_W-1:0] shown;
      logic [BAR_W-1:0] previous;
      logic [BAR_W-1:0] peak;
      logic [BAR_W-1:0] fall;
   } bar_beat_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = CMD_UPDATE;
   logic [COL_W-1:0]     req_column = '0;
   logic [LVL_W-1:0]     req_level_left = '0;
   logic [LVL_W-1:0]     req_level_right = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [COL_W-1:0]     rsp_out_column;
   logic [BAR_W-1:0]     rsp_scaled_level;
   logic [BAR_W-1:0]     rsp_bar_shown;
   logic [BAR_W-1:0]     rsp_bar_previous;
   logic [BAR_W-1:0]     rsp_peak_marker;
   logic [BAR_W-1:0]     rsp_fall_speed;

   spectrum_bar_falloff_peak_hold_core #(
      .COLUMNS (COLUMNS),
      .DB_STEPS(DB_STEPS)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_column      (req_column),
      .req_level_left  (req_level_left),
      .req_level_right (req_level_right),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_column  (rsp_out_column),
      .rsp_scaled_level(rsp_scaled_level),
      .rsp_bar_shown   (rsp_bar_shown),
      .rsp_bar_previous(rsp_bar_previous),
      .rsp_peak_marker (rsp_peak_marker),
      .rsp_fall_speed  (rsp_fall_speed)
   );

   always #5 clock = ~clock;

   // mirror of the display registers and of the column store
   logic [MODE_W-1:0] disp_mode   = MODE_RIGHT;
   logic [HGT_W-1:0]  disp_height = 8'd64;
   logic              disp_peaks  = 1'b1;
   int                bar_show [SETS][COLUMNS];
   int                bar_peak [SETS][COLUMNS];
   int                bar_fall [SETS][COLUMNS];

   bar_beat_type pending_bars [$];
   bit        steady = 1'b0;
   int        errors = 0;
   int        n_beats = 0;
   int        n_checked = 0;
   int        n_clears = 0;
   int        n_csr_writes = 0;

   function automatic void wipe_bars();
      for (int s = 0; s < SETS; s++) begin
         for (int c = 0; c < COLUMNS; c++) begin
            bar_show[s][c] = 0;
            bar_peak[s][c] = 0;
            bar_fall[s][c] = 0;
         end
      end
   endfunction

   // advance one column of the mirror and return the response it must give
   function automatic bar_beat_type animate_bar(input logic cmd, input logic [COL_W-1:0] col,
                                                input logic [LVL_W-1:0] lvl_l,
                                                input logic [LVL_W-1:0] lvl_r);
      bar_beat_type res;
      int set, level, raw, shown, peak, fall;
      res = '0;
      res.column = col;
      if (cmd == CMD_CLEAR) begin
         wipe_bars();
         return res;
      end
      case (disp_mode)
         MODE_LEFT: begin
            set = 0;
            level = int'(lvl_l);
         end
         MODE_RIGHT: begin
            set = 1;
            level = int'(lvl_r);
         end
         default: begin
            set = 2;
            level = (lvl_l > lvl_r) ? int'(lvl_l) : int'(lvl_r);
         end
      endcase
      raw = (level * int'(disp_height)) / DB_STEPS;
      if (raw > 255) raw = 255;
      res.scaled = raw[7:0];
      shown = bar_show[set][col];
      peak  = bar_peak[set][col];
      fall  = bar_fall[set][col];
      res.previous = shown[7:0];
      if (raw < shown) begin
         if (shown >= fall) begin
            shown -= fall;
            if (fall < 255) fall++;
         end else begin
            shown = 0;
         end
      end
      if (raw > shown) begin
         shown = raw;
         fall = 1;
      end
      if (peak <= raw) begin
         peak = (raw + 1 > 255) ? 255 : raw + 1;
      end else if (peak != 0 && peak > shown + 1) begin
         peak--;
      end
      bar_show[set][col] = shown;
      bar_peak[set][col] = peak;
      bar_fall[set][col] = fall;
      res.shown = shown[7:0];
      res.peak  = disp_peaks ? peak[7:0] : 8'd0;
      res.fall  = fall[7:0];
      return res;
   endfunction

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_beat(input logic cmd, input logic [COL_W-1:0] col,
                            input logic [LVL_W-1:0] lvl_l, input logic [LVL_W-1:0] lvl_r);
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_column      <= col;
      req_level_left  <= lvl_l;
      req_level_right <= lvl_r;
      do @(posedge clock); while (!req_ready);
      pending_bars.push_back(animate_bar(cmd, col, lvl_l, lvl_r));
      n_beats++;
      if (cmd == CMD_CLEAR) n_clears++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_bars.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_display(input logic [MODE_W-1:0] mode, input logic [HGT_W-1:0] height,
                              input logic peaks);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_CHANNEL_MODE;
      csr_wdata <= CSR_DAT_W'(mode);
      @(negedge clock);
      csr_index <= CSR_BAR_HEIGHT;
      csr_wdata <= height;
      @(negedge clock);
      csr_index <= CSR_PEAKS_ENABLED;
      csr_wdata <= CSR_DAT_W'(peaks);
      @(negedge clock);
      csr_we <= 1'b0;
      disp_mode    = mode;
      disp_height  = height;
      disp_peaks   = peaks;
      n_csr_writes += 3;
   endtask

   // mostly low levels so bars fall, some high so they jump back up
   function automatic logic [LVL_W-1:0] pick_level();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return LVL_W'($urandom_range(0, 4));
      if (r < 7) return LVL_W'($urandom_range(0, 31));
      return LVL_W'($urandom_range(24, 31));
   endfunction

   task automatic run_random_phase(input int beats);
      logic [COL_W-1:0] hot [4];
      logic [COL_W-1:0] col;
      foreach (hot[i]) hot[i] = COL_W'($urandom_range(0, 63));
      repeat (beats) begin
         if ($urandom_range(0, 79) == 0) begin
            send_beat(CMD_CLEAR, COL_W'($urandom_range(0, 63)), LVL_W'($urandom_range(0, 31)),
                      LVL_W'($urandom_range(0, 31)));
         end else begin
            col = ($urandom_range(0, 3) != 0) ? hot[$urandom_range(0, 3)]
                                              : COL_W'($urandom_range(0, 63));
            send_beat(CMD_UPDATE, col, pick_level(), pick_level());
         end
      end
   endtask

   // rise, accelerating fall and peak decay on the reset settings
   task automatic test_rise_and_fall();
      send_beat(CMD_UPDATE, 6'd0, 5'd0, 5'd31);
      repeat (4) send_beat(CMD_UPDATE, 6'd0, 5'd31, 5'd0);
      send_beat(CMD_UPDATE, 6'd0, 5'd0, 5'd20);
      send_beat(CMD_UPDATE, 6'd63, 5'd31, 5'd31);
      send_beat(CMD_UPDATE, 6'd63, 5'd0, 5'd0);
   endtask

   // fall step larger than the bar: bar hits zero and keeps its speed
   task automatic test_bar_floor();
      send_beat(CMD_UPDATE, 6'd7, 5'd0, 5'd1);
      send_beat(CMD_UPDATE, 6'd7, 5'd0, 5'd0);
      send_beat(CMD_UPDATE, 6'd7, 5'd0, 5'd0);
   endtask

   task automatic test_channel_modes();
      set_display(MODE_LEFT, 8'd254, 1'b1);
      send_beat(CMD_UPDATE, 6'd5, 5'd31, 5'd0);
      send_beat(CMD_UPDATE, 6'd5, 5'd1, 5'd31);
      set_display(MODE_BOTH, 8'd1, 1'b0);
      send_beat(CMD_UPDATE, 6'd5, 5'd31, 5'd16);
      send_beat(CMD_UPDATE, 6'd42, 5'd3, 5'd31);
      set_display(MODE_BOTH_ALT, 8'd128, 1'b1);
      send_beat(CMD_UPDATE, 6'd5, 5'd0, 5'd31);
      send_beat(CMD_UPDATE, 6'd5, 5'd31, 5'd17);
   endtask

   task automatic test_clear();
      send_beat(CMD_UPDATE, 6'd42, 5'd25, 5'd30);
      send_beat(CMD_CLEAR, 6'd42, 5'd31, 5'd31);
      send_beat(CMD_UPDATE, 6'd42, 5'd0, 5'd0);
      send_beat(CMD_UPDATE, 6'd5, 5'd10, 5'd10);
   endtask

   task automatic test_random_traffic();
      logic [MODE_W-1:0] modes [8]   = '{MODE_RIGHT, MODE_LEFT, MODE_BOTH, MODE_BOTH_ALT,
                                         MODE_LEFT, MODE_BOTH, MODE_RIGHT, MODE_BOTH};
      logic [HGT_W-1:0]  heights [8] = '{8'd64, 8'd254, 8'd1, 8'd200, 8'd37, 8'd254, 8'd1,
                                         8'd97};
      logic              peaks [8]   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
      for (int p = 0; p < 8; p++) begin
         set_display(modes[p], heights[p], peaks[p]);
         run_random_phase(170);
      end
   endtask

   // last stretch without idling on either side
   task automatic test_random_steady();
      set_display(MODE_W'($urandom_range(0, 3)), HGT_W'($urandom_range(1, 254)),
                  1'($urandom_range(0, 1)));
      steady = 1'b1;
      run_random_phase(180);
   endtask

   // response side stalls
   initial begin
      forever begin
         @(negedge clock);
         if (!steady && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      bar_beat_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_out_column, rsp_scaled_level, rsp_bar_shown, rsp_bar_previous,
                 rsp_peak_marker, rsp_fall_speed};
         if (pending_bars.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("ERROR: response beat with nothing expected, column %0d", got.column);
         end else begin
            want = pending_bars.pop_front();
            n_checked++;
            if (got.column !== want.column || got.scaled !== want.scaled ||
                got.shown !== want.shown || got.previous !== want.previous ||
                got.peak !== want.peak || got.fall !== want.fall) begin
               errors++;
               if (errors <= 10) begin
                  $write("ERROR: beat %0d exp col=%0d lvl=%0d show=%0d prev=%0d peak=%0d fall=%0d",
                         n_checked, want.column, want.scaled, want.shown, want.previous,
                         want.peak, want.fall);
                  $display(" got col=%0d lvl=%0d show=%0d prev=%0d peak=%0d fall=%0d",
                           got.column, got.scaled, got.shown, got.previous, got.peak,
                           got.fall);
               end
            end
         end
      end
   end

   initial begin
      wipe_bars();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_rise_and_fall();
      test_bar_floor();
      test_clear();
      test_channel_modes();
      test_random_traffic();
      test_random_steady();
      drain_results();
      repeat (4) @(negedge clock);
      $display("Covered %0d beats (%0d clears), %0d responses checked, %0d register writes,",
               n_beats, n_clears, n_checked, n_csr_writes);
      $display("all channel modes, heights 1 to 254, peaks on and off; %0d mismatches.",
               errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
